// ===== design/uhcdp_pkg.sv =====
// uhcdp_pkg: shared constants, command and result types for the
// USB HID configuration descriptor parser.
// No dependencies; the design files that use it refer to it by scoped names.
package uhcdp_pkg;

    // Default cap on the descriptor length, in bytes
    localparam int MAX_DESC_BYTES_DEF = 64;

    // Byte position counter saturates at its top value
    localparam logic [8:0]  POS_LIMIT  = 9'd511;
    localparam logic [8:0]  WALK_START = 9'd9;

    // Header positions
    localparam logic [8:0]  POS_TOTAL_LO = 9'd2;
    localparam logic [8:0]  POS_TOTAL_HI = 9'd3;
    localparam logic [8:0]  POS_CONFIG   = 9'd5;

    // Offsets inside a sub-descriptor
    localparam logic [8:0]  OFF_TYPE   = 9'd1;
    localparam logic [8:0]  OFF_IFACE  = 9'd2;
    localparam logic [8:0]  OFF_CLASS  = 9'd5;
    localparam logic [8:0]  OFF_SUB    = 9'd6;
    localparam logic [8:0]  OFF_PROTO  = 9'd7;
    localparam logic [8:0]  OFF_FINISH = 9'd8;

    // Minimum length of an interface or HID sub-descriptor
    localparam logic [7:0]  MIN_SUB_LEN = 8'd9;

    // Descriptor codes
    localparam logic [7:0]  TYPE_INTERFACE = 8'h04;
    localparam logic [7:0]  TYPE_HID       = 8'h21;
    localparam logic [7:0]  CLASS_HID      = 8'h03;
    localparam logic [7:0]  SUBCLASS_BOOT  = 8'h01;
    localparam logic [7:0]  PROTO_KEYBOARD = 8'h01;
    localparam logic [7:0]  PROTO_MOUSE    = 8'h02;

    // Report length limits and defaults
    localparam logic [7:0]  REPORT_MAX   = 8'd64;
    localparam logic [6:0]  REPLEN_KBD   = 7'd8;
    localparam logic [6:0]  REPLEN_OTHER = 7'd3;

    // Work handed from the front part to the back part, one per byte
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CONFIG,
        OP_TYPE,
        OP_IFACE,
        OP_CLASS,
        OP_SUB,
        OP_PROTO,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
        logic [6:0] used_len;
    } cmd_t;

    typedef struct packed {
        logic [7:0] config_value;
        logic       hid_found;
        logic [7:0] interface_number;
        logic [7:0] boot_protocol;
        logic       keyboard_flag;
        logic       mouse_flag;
        logic [6:0] report_length;
        logic [6:0] used_length;
    } result_t;

endpackage

// ===== design/uhcdp_fifo.sv =====
// uhcdp_fifo: small first-in first-out queue in flip-flops.
// Generic width and depth; no package dependency.
module uhcdp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== design/uhcdp_front.sv =====
// uhcdp_front: tracks byte position, total length and sub-descriptor
// boundaries, and tags each byte with the field it carries.
// Depends on uhcdp_pkg.
module uhcdp_front #(
    parameter int MAX_DESC_BYTES = uhcdp_pkg::MAX_DESC_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        desc_byte,
    input  logic              last_byte,
    output uhcdp_pkg::cmd_t   cmd
);

    localparam int          CAP_W   = $clog2(MAX_DESC_BYTES + 1);
    localparam logic [15:0] CAP_MAX = 16'(MAX_DESC_BYTES);

    logic [8:0]       pos_reg, pos_next;
    logic [7:0]       total_low_reg, total_low_next;
    logic [CAP_W-1:0] capped_reg, capped_next;
    logic [8:0]       next_start_reg, next_start_next;
    logic [7:0]       cur_len_reg, cur_len_next;
    logic             fits_reg, fits_next;
    logic             stopped_reg, stopped_next;

    logic [CAP_W-1:0] capped_upd;
    logic [8:0]       capped_ext;
    logic [8:0]       end_pos;
    logic [8:0]       offset;
    logic             walk_on;
    uhcdp_pkg::op_t   op;

    function automatic logic [CAP_W-1:0] cap_total(input logic [15:0] raw);
        return (raw > CAP_MAX) ? CAP_W'(CAP_MAX) : CAP_W'(raw);
    endfunction

    // Header capture, walk and classification
    always_comb
    begin
        pos_next        = pos_reg;
        total_low_next  = total_low_reg;
        next_start_next = next_start_reg;
        cur_len_next    = cur_len_reg;
        fits_next       = fits_reg;
        stopped_next    = stopped_reg;
        op              = uhcdp_pkg::OP_NONE;

        capped_upd = capped_reg;
        if (pos_reg == uhcdp_pkg::POS_TOTAL_LO)
        begin
            total_low_next = desc_byte;
            capped_upd     = cap_total({8'd0, desc_byte});
        end
        else if (pos_reg == uhcdp_pkg::POS_TOTAL_HI)
            capped_upd = cap_total({desc_byte, total_low_reg});
        else if (pos_reg == uhcdp_pkg::POS_CONFIG)
            op = uhcdp_pkg::OP_CONFIG;
        capped_next = capped_upd;

        capped_ext = 9'(capped_upd);
        end_pos    = pos_reg + {1'b0, desc_byte};
        offset     = pos_reg + {1'b0, cur_len_reg} - next_start_reg;
        walk_on    = !stopped_reg && (pos_reg >= uhcdp_pkg::WALK_START)
                     && (pos_reg < capped_ext);

        if (walk_on)
        begin
            if (pos_reg == next_start_reg)
            begin
                // length byte of a new sub-descriptor; zero ends the walk
                if (desc_byte == 8'd0)
                    stopped_next = 1'b1;
                else
                begin
                    cur_len_next    = desc_byte;
                    fits_next       = (desc_byte >= uhcdp_pkg::MIN_SUB_LEN)
                                      && (end_pos <= capped_ext);
                    next_start_next = end_pos;
                end
            end
            else
            begin
                case (offset)
                    uhcdp_pkg::OFF_TYPE:   op = uhcdp_pkg::OP_TYPE;
                    uhcdp_pkg::OFF_IFACE:  op = uhcdp_pkg::OP_IFACE;
                    uhcdp_pkg::OFF_CLASS:  op = uhcdp_pkg::OP_CLASS;
                    uhcdp_pkg::OFF_SUB:    op = uhcdp_pkg::OP_SUB;
                    uhcdp_pkg::OFF_PROTO:  op = uhcdp_pkg::OP_PROTO;
                    uhcdp_pkg::OFF_FINISH:
                        op = fits_reg ? uhcdp_pkg::OP_FINISH : uhcdp_pkg::OP_NONE;
                    default:               op = uhcdp_pkg::OP_NONE;
                endcase
            end
        end

        if (pos_reg < uhcdp_pkg::POS_LIMIT)
            pos_next = pos_reg + 9'd1;

        // final byte: back to the start state for the next descriptor
        if (last_byte)
        begin
            pos_next        = '0;
            total_low_next  = '0;
            capped_next     = '0;
            next_start_next = uhcdp_pkg::WALK_START;
            cur_len_next    = '0;
            fits_next       = 1'b0;
            stopped_next    = 1'b0;
        end

        cmd.op       = op;
        cmd.data     = desc_byte;
        cmd.last     = last_byte;
        cmd.used_len = 7'(capped_upd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            total_low_reg  <= '0;
            capped_reg     <= '0;
            next_start_reg <= uhcdp_pkg::WALK_START;
            cur_len_reg    <= '0;
            fits_reg       <= 1'b0;
            stopped_reg    <= 1'b0;
        end
        else if (take)
        begin
            pos_reg        <= pos_next;
            total_low_reg  <= total_low_next;
            capped_reg     <= capped_next;
            next_start_reg <= next_start_next;
            cur_len_reg    <= cur_len_next;
            fits_reg       <= fits_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

// ===== design/uhcdp_back.sv =====
// uhcdp_back: applies tagged bytes to the field captures and result
// registers, and builds one result on the final byte.
// Depends on uhcdp_pkg.
module uhcdp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  uhcdp_pkg::cmd_t      cmd,
    output logic                 cmd_take,
    input  logic                 res_full,
    output logic                 res_push,
    output uhcdp_pkg::result_t   res
);

    // Field captures of the current sub-descriptor
    logic [7:0] type_reg,  type_next;
    logic [7:0] c_if_reg,  c_if_next;
    logic [7:0] c_cls_reg, c_cls_next;
    logic [7:0] c_sub_reg, c_sub_next;
    logic [7:0] c_pro_reg, c_pro_next;
    logic [7:0] c_rl_reg,  c_rl_next;
    // Result registers
    logic [7:0] cfg_reg,   cfg_next;
    logic       found_reg, found_next;
    logic [7:0] iface_reg, iface_next;
    logic [7:0] proto_reg, proto_next;
    logic [6:0] rl_reg,    rl_next;

    logic [7:0] rl_cand;
    logic       kb;
    logic       ms;

    assign cmd_take = cmd_valid && !res_full;
    assign res_push = cmd_take && cmd.last;

    always_comb
    begin
        type_next  = type_reg;
        c_if_next  = c_if_reg;
        c_cls_next = c_cls_reg;
        c_sub_next = c_sub_reg;
        c_pro_next = c_pro_reg;
        c_rl_next  = c_rl_reg;
        cfg_next   = cfg_reg;
        found_next = found_reg;
        iface_next = iface_reg;
        proto_next = proto_reg;
        rl_next    = rl_reg;
        // a nonzero high byte means a report longer than the limit
        rl_cand    = (cmd.data != 8'd0) ? 8'd0 : c_rl_reg;

        case (cmd.op)
            uhcdp_pkg::OP_CONFIG: cfg_next   = cmd.data;
            uhcdp_pkg::OP_TYPE:   type_next  = cmd.data;
            uhcdp_pkg::OP_IFACE:  c_if_next  = cmd.data;
            uhcdp_pkg::OP_CLASS:  c_cls_next = cmd.data;
            uhcdp_pkg::OP_SUB:    c_sub_next = cmd.data;
            uhcdp_pkg::OP_PROTO:
            begin
                c_pro_next = cmd.data;
                c_rl_next  = cmd.data;
            end
            uhcdp_pkg::OP_FINISH:
            begin
                if (type_reg == uhcdp_pkg::TYPE_INTERFACE)
                begin
                    if (c_cls_reg == uhcdp_pkg::CLASS_HID
                        && c_sub_reg == uhcdp_pkg::SUBCLASS_BOOT)
                    begin
                        found_next = 1'b1;
                        iface_next = c_if_reg;
                        proto_next = c_pro_reg;
                    end
                end
                else if (type_reg == uhcdp_pkg::TYPE_HID)
                begin
                    c_rl_next = rl_cand;
                    if (rl_cand != 8'd0 && rl_cand <= uhcdp_pkg::REPORT_MAX)
                        rl_next = 7'(rl_cand);
                end
            end
            default: ;
        endcase

        // Result from the updated registers
        kb = found_next && (proto_next == uhcdp_pkg::PROTO_KEYBOARD);
        ms = found_next && (proto_next == uhcdp_pkg::PROTO_MOUSE);
        res.config_value     = cfg_next;
        res.hid_found        = found_next;
        res.interface_number = iface_next;
        res.boot_protocol    = proto_next;
        res.keyboard_flag    = kb;
        res.mouse_flag       = ms;
        res.report_length    = (rl_next != 7'd0) ? rl_next
                             : (kb ? uhcdp_pkg::REPLEN_KBD : uhcdp_pkg::REPLEN_OTHER);
        res.used_length      = cmd.used_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg  <= '0;
            c_if_reg  <= '0;
            c_cls_reg <= '0;
            c_sub_reg <= '0;
            c_pro_reg <= '0;
            c_rl_reg  <= '0;
            cfg_reg   <= '0;
            found_reg <= 1'b0;
            iface_reg <= '0;
            proto_reg <= '0;
            rl_reg    <= '0;
        end
        else if (cmd_take)
        begin
            if (cmd.last)
            begin
                // descriptor done: clear for the next one
                type_reg  <= '0;
                c_if_reg  <= '0;
                c_cls_reg <= '0;
                c_sub_reg <= '0;
                c_pro_reg <= '0;
                c_rl_reg  <= '0;
                cfg_reg   <= '0;
                found_reg <= 1'b0;
                iface_reg <= '0;
                proto_reg <= '0;
                rl_reg    <= '0;
            end
            else
            begin
                type_reg  <= type_next;
                c_if_reg  <= c_if_next;
                c_cls_reg <= c_cls_next;
                c_sub_reg <= c_sub_next;
                c_pro_reg <= c_pro_next;
                c_rl_reg  <= c_rl_next;
                cfg_reg   <= cfg_next;
                found_reg <= found_next;
                iface_reg <= iface_next;
                proto_reg <= proto_next;
                rl_reg    <= rl_next;
            end
        end
    end

endmodule

// ===== design/usb_hid_config_descriptor_parser.sv =====
// usb_hid_config_descriptor_parser: top level, front part, command queue,
// back part and result queue. Depends on uhcdp_pkg, uhcdp_front,
// uhcdp_back and uhcdp_fifo.
//
// Usage:
//   Input queue: drive desc_byte with last_byte and raise push; a byte
//   transfers at a clock edge with push high and full low. Send the bytes of
//   one configuration descriptor in order and mark the final one last_byte.
//   Result queue: while empty is low the oldest result is on the result
//   ports; it transfers at a clock edge with pop high.
//   One result follows each byte marked last; other bytes produce none.
// Throughput: one byte per cycle while full is low. The front part classifies
// each byte with combinational position compares and 9-bit adds, and the back
// part does one register update per byte.
// Path: a final byte goes through the command queue, then the back part into
// the result queue, before its result shows on the result ports.
// Stalls: when pop stays low the result queue fills, the back part stops
// draining the command queue, and full rises once that queue is full;
// no byte or result is lost.
// Reset: rst_n low clears both queues and all parse state at once.
module usb_hid_config_descriptor_parser #(
    parameter int MAX_DESC_BYTES = uhcdp_pkg::MAX_DESC_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] desc_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] config_value,
    output logic       hid_found,
    output logic [7:0] interface_number,
    output logic [7:0] boot_protocol,
    output logic       keyboard_flag,
    output logic       mouse_flag,
    output logic [6:0] report_length,
    output logic [6:0] used_length
);

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    uhcdp_pkg::cmd_t    front_cmd;
    uhcdp_pkg::cmd_t    back_cmd;
    uhcdp_pkg::result_t back_res;
    uhcdp_pkg::result_t out_res;
    logic               in_take;
    logic               cmd_empty;
    logic               cmd_take;
    logic               res_full;
    logic               res_push;

    assign in_take = push && !full;

    // Front: position tracking and byte classification
    uhcdp_front #(
        .MAX_DESC_BYTES(MAX_DESC_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (in_take),
        .desc_byte(desc_byte),
        .last_byte(last_byte),
        .cmd      (front_cmd)
    );

    // Command queue between front and back
    uhcdp_fifo #(
        .WIDTH($bits(uhcdp_pkg::cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (in_take),
        .wr_data(front_cmd),
        .rd_en  (cmd_take),
        .rd_data(back_cmd),
        .full   (full),
        .empty  (cmd_empty)
    );

    // Back: field capture and result build
    uhcdp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(!cmd_empty),
        .cmd      (back_cmd),
        .cmd_take (cmd_take),
        .res_full (res_full),
        .res_push (res_push),
        .res      (back_res)
    );

    // Result queue
    uhcdp_fifo #(
        .WIDTH($bits(uhcdp_pkg::result_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(back_res),
        .rd_en  (pop),
        .rd_data(out_res),
        .full   (res_full),
        .empty  (empty)
    );

    assign config_value     = out_res.config_value;
    assign hid_found        = out_res.hid_found;
    assign interface_number = out_res.interface_number;
    assign boot_protocol    = out_res.boot_protocol;
    assign keyboard_flag    = out_res.keyboard_flag;
    assign mouse_flag       = out_res.mouse_flag;
    assign report_length    = out_res.report_length;
    assign used_length      = out_res.used_length;

endmodule

// ===== design/uhcdp_checker.sv =====
// uhcdp_checker: port-level assertions for the descriptor parser,
// bound to the top level. Depends on usb_hid_config_descriptor_parser.
module uhcdp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] config_value,
    input logic       hid_found,
    input logic [7:0] interface_number,
    input logic [7:0] boot_protocol,
    input logic       keyboard_flag,
    input logic       mouse_flag,
    input logic [6:0] report_length
);

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result waiting during reset");

    // A waiting result holds until it transfers
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(config_value)
                              && $stable(report_length) && $stable(hid_found)))
        else $error("waiting result changed");

    // Keyboard and mouse flags only with a boot interface, never both
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!(keyboard_flag && mouse_flag)
                    && ((keyboard_flag || mouse_flag) ? hid_found : 1'b1)))
        else $error("inconsistent device flags");

    // Without a boot interface the interface fields read zero
    a_no_hid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hid_found) |-> (interface_number == 8'd0 && boot_protocol == 8'd0))
        else $error("interface fields set without boot interface");

    // Report length always in range
    a_replen: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (report_length != 7'd0 && report_length <= 7'd64))
        else $error("report length out of range");

endmodule

bind usb_hid_config_descriptor_parser uhcdp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .config_value    (config_value),
    .hid_found       (hid_found),
    .interface_number(interface_number),
    .boot_protocol   (boot_protocol),
    .keyboard_flag   (keyboard_flag),
    .mouse_flag      (mouse_flag),
    .report_length   (report_length)
);

// ===== test/descriptor_parse_checker.sv =====
`timescale 1ns / 100ps
// descriptor_parse_checker: watches the byte and result queues of the
// descriptor parser, predicts each result byte by byte and compares it.
// Depends on uhcdp_pkg for codes, offsets and the result_t layout.
module descriptor_parse_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] desc_byte,
    input  logic       last_byte,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] config_value,
    input  logic       hid_found,
    input  logic [7:0] interface_number,
    input  logic [7:0] boot_protocol,
    input  logic       keyboard_flag,
    input  logic       mouse_flag,
    input  logic [6:0] report_length,
    input  logic [6:0] used_length,
    output int         mismatches,
    output int         results_waiting
);

    localparam int CAP_BYTES = uhcdp_pkg::MAX_DESC_BYTES_DEF;

    // Parse state of the descriptor in flight
    logic [8:0] pos;
    logic [6:0] cap_len;
    logic [7:0] total_lo;
    logic [8:0] sub_end;
    logic [7:0] sub_len;
    logic [7:0] sub_type;
    logic       walk_done;
    logic       sub_fits;
    logic [7:0] f_iface, f_class, f_sub, f_proto, f_replen;

    // Values collected for the result
    logic [7:0] r_config;
    logic       r_found;
    logic [7:0] r_iface, r_proto, r_replen;

    uhcdp_pkg::result_t parsed_configs[$];

    function automatic logic [6:0] capped(input int unsigned raw);
        return (raw > CAP_BYTES) ? 7'(CAP_BYTES) : 7'(raw);
    endfunction

    task clear_parse();
        pos       = '0;
        cap_len   = '0;
        total_lo  = '0;
        sub_end   = uhcdp_pkg::WALK_START;
        sub_len   = '0;
        sub_type  = '0;
        walk_done = 1'b0;
        sub_fits  = 1'b0;
        f_iface   = '0;
        f_class   = '0;
        f_sub     = '0;
        f_proto   = '0;
        f_replen  = '0;
        r_config  = '0;
        r_found   = 1'b0;
        r_iface   = '0;
        r_proto   = '0;
        r_replen  = '0;
    endtask

    // Advance the parse by one byte; a final byte queues the result
    task track_descriptor_byte(input logic [7:0] b, input logic last);
        int unsigned        p;
        int unsigned        off;
        uhcdp_pkg::result_t res;
        p = {23'd0, pos};

        // header fields
        if (p == uhcdp_pkg::POS_TOTAL_LO)
        begin
            total_lo = b;
            cap_len  = capped({24'd0, b});
        end
        else if (p == uhcdp_pkg::POS_TOTAL_HI)
            cap_len = capped({16'd0, b, total_lo});
        else if (p == uhcdp_pkg::POS_CONFIG)
            r_config = b;

        // sub-descriptor walk inside the capped length
        if (!walk_done && p >= uhcdp_pkg::WALK_START && p < cap_len)
        begin
            if (p == sub_end)
            begin
                if (b == 8'd0)
                    walk_done = 1'b1;
                else
                begin
                    sub_len  = b;
                    sub_type = '0;
                    sub_fits = (b >= uhcdp_pkg::MIN_SUB_LEN) && (p + b <= cap_len);
                    sub_end  = 9'(p + b);
                end
            end
            else
            begin
                off = p + sub_len - sub_end;
                case (off)
                    uhcdp_pkg::OFF_TYPE:  sub_type = b;
                    uhcdp_pkg::OFF_IFACE: f_iface = b;
                    uhcdp_pkg::OFF_CLASS: f_class = b;
                    uhcdp_pkg::OFF_SUB:   f_sub = b;
                    uhcdp_pkg::OFF_PROTO:
                    begin
                        f_proto  = b;
                        f_replen = b;
                    end
                    uhcdp_pkg::OFF_FINISH:
                    begin
                        // cut-off or too short sub-descriptors apply nothing
                        if (sub_fits)
                        begin
                            if (sub_type == uhcdp_pkg::TYPE_INTERFACE)
                            begin
                                if (f_class == uhcdp_pkg::CLASS_HID
                                    && f_sub == uhcdp_pkg::SUBCLASS_BOOT)
                                begin
                                    r_found = 1'b1;
                                    r_iface = f_iface;
                                    r_proto = f_proto;
                                end
                            end
                            else if (sub_type == uhcdp_pkg::TYPE_HID)
                            begin
                                // nonzero high byte means length above the limit
                                if (b != 8'd0)
                                    f_replen = '0;
                                if (f_replen >= 8'd1 && f_replen <= uhcdp_pkg::REPORT_MAX)
                                    r_replen = f_replen;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (pos < uhcdp_pkg::POS_LIMIT)
            pos = pos + 9'd1;

        if (last)
        begin
            res.config_value     = r_config;
            res.hid_found        = r_found;
            res.interface_number = r_iface;
            res.boot_protocol    = r_proto;
            res.keyboard_flag    = r_found && r_proto == uhcdp_pkg::PROTO_KEYBOARD;
            res.mouse_flag       = r_found && r_proto == uhcdp_pkg::PROTO_MOUSE;
            if (r_replen == 8'd0)
                res.report_length = res.keyboard_flag ? uhcdp_pkg::REPLEN_KBD
                                                      : uhcdp_pkg::REPLEN_OTHER;
            else
                res.report_length = r_replen[6:0];
            res.used_length = cap_len;
            parsed_configs.push_back(res);
            clear_parse();
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task check_result();
        uhcdp_pkg::result_t want;
        if (parsed_configs.size() == 0)
        begin
            $error("result transfer with no descriptor outstanding");
            mismatches++;
        end
        else
        begin
            want = parsed_configs.pop_front();
            check_field("config_value", want.config_value, config_value);
            check_field("hid_found", want.hid_found, hid_found);
            check_field("interface_number", want.interface_number, interface_number);
            check_field("boot_protocol", want.boot_protocol, boot_protocol);
            check_field("keyboard_flag", want.keyboard_flag, keyboard_flag);
            check_field("mouse_flag", want.mouse_flag, mouse_flag);
            check_field("report_length", want.report_length, report_length);
            check_field("used_length", want.used_length, used_length);
        end
    endtask

    // Result side first so a same-edge final byte never pairs with this pop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            parsed_configs.delete();
            mismatches      = 0;
            results_waiting = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (push && !full)
                track_descriptor_byte(desc_byte, last_byte);
            results_waiting = parsed_configs.size();
        end
    end

endmodule

// ===== test/usb_hid_config_descriptor_parser_test.sv =====
`timescale 1ns / 100ps
// usb_hid_config_descriptor_parser_test: clock, reset and descriptor stimulus
// for the parser, with descriptor_parse_checker alongside giving the verdict.
// Depends on uhcdp_pkg, usb_hid_config_descriptor_parser, descriptor_parse_checker.
module usb_hid_config_descriptor_parser_test;

    localparam int ITEM_TARGET   = 1050;
    localparam int MIN_RESULTS   = 60;
    localparam int HOLD_CYCLES   = 500;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [7:0] TYPE_CONFIG   = 8'h02;
    localparam logic [7:0] TYPE_ENDPOINT = 8'h05;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] desc_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] config_value;
    logic       hid_found;
    logic [7:0] interface_number;
    logic [7:0] boot_protocol;
    logic       keyboard_flag;
    logic       mouse_flag;
    logic [6:0] report_length;
    logic [6:0] used_length;

    int mismatches;
    int results_waiting;

    // test state; calm and hold_requests are shared with the result sink
    logic calm = 1'b0;
    int   hold_requests = 0;
    int   bytes_sent = 0;
    int   frames_sent = 0;
    int   cycle_count = 0;

    logic [7:0] frame[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    usb_hid_config_descriptor_parser dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .desc_byte        (desc_byte),
        .last_byte        (last_byte),
        .empty            (empty),
        .pop              (pop),
        .config_value     (config_value),
        .hid_found        (hid_found),
        .interface_number (interface_number),
        .boot_protocol    (boot_protocol),
        .keyboard_flag    (keyboard_flag),
        .mouse_flag       (mouse_flag),
        .report_length    (report_length),
        .used_length      (used_length)
    );

    descriptor_parse_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .desc_byte        (desc_byte),
        .last_byte        (last_byte),
        .empty            (empty),
        .pop              (pop),
        .config_value     (config_value),
        .hid_found        (hid_found),
        .interface_number (interface_number),
        .boot_protocol    (boot_protocol),
        .keyboard_flag    (keyboard_flag),
        .mouse_flag       (mouse_flag),
        .report_length    (report_length),
        .used_length      (used_length),
        .mismatches       (mismatches),
        .results_waiting  (results_waiting)
    );

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("usb_hid_config_descriptor_parser verification failed");
            $finish;
        end
    end

    // Result sink: random pop with occasional long hold-offs on request
    initial
    begin : result_sink
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (calm)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 99) >= 16);
        end
    end

    // One byte transfer, with random idle cycles ahead of it
    task send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        desc_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    task send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    task wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (results_waiting != 0)
            @(negedge clk);
    endtask

    // Configuration descriptor with random content; sub-descriptor lengths, header
    // length and tail sometimes off
    task build_config_frame();
        logic [7:0]  sub[12];
        int          pick;
        int          len_pick;
        int          rl_pick;
        int          sub_len;
        int          cut;
        logic [15:0] total;
        frame.delete();
        frame.push_back(8'd9);
        frame.push_back(TYPE_CONFIG);
        frame.push_back(8'd0);
        frame.push_back(8'd0);
        repeat (5) frame.push_back(8'($urandom));
        repeat ($urandom_range(1, 5))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                frame.push_back(8'd0);   // zero length ends the walk
            else
            begin
                foreach (sub[i])
                    sub[i] = 8'($urandom);
                if (pick < 40)
                    sub[1] = uhcdp_pkg::TYPE_INTERFACE;
                else if (pick < 75)
                    sub[1] = uhcdp_pkg::TYPE_HID;
                else if (pick < 90)
                    sub[1] = TYPE_ENDPOINT;
                // boot interface fields, mostly matching
                sub[5] = ($urandom_range(0, 9) < 8) ? uhcdp_pkg::CLASS_HID
                                                    : 8'($urandom);
                sub[6] = ($urandom_range(0, 9) < 8) ? uhcdp_pkg::SUBCLASS_BOOT
                                                    : 8'($urandom);
                sub[7] = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom);
                if (sub[1] == uhcdp_pkg::TYPE_HID)
                begin
                    // report length: in range, zero or too big
                    rl_pick = $urandom_range(0, 99);
                    if (rl_pick < 60)
                        sub[7] = 8'($urandom_range(1, 64));
                    else if (rl_pick < 75)
                        sub[7] = 8'd0;
                    else
                        sub[7] = 8'($urandom_range(65, 255));
                    sub[8] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0;
                end
                len_pick = $urandom_range(0, 99);
                if (len_pick < 85)
                    sub_len = (sub[1] == TYPE_ENDPOINT) ? 7 : 9;
                else if (len_pick < 95)
                    sub_len = $urandom_range(10, 12);
                else
                    sub_len = $urandom_range(1, 8);
                sub[0] = 8'(sub_len);
                for (int i = 0; i < sub_len; i++)
                    frame.push_back(sub[i]);
            end
        end

        // total length: exact, short, long or with a high byte
        total = 16'(frame.size());
        case ($urandom_range(0, 9))
            0: total = 16'($urandom_range(0, total));
            1: total = 16'($urandom_range(0, 255));
            2: total = {8'($urandom_range(1, 255)), 8'($urandom)};
            default: ;
        endcase
        frame[2] = total[7:0];
        frame[3] = total[15:8];

        // stream cut short or carrying trailing bytes
        case ($urandom_range(0, 9))
            0:
            begin
                cut = $urandom_range(1, frame.size());
                while (frame.size() > cut)
                    frame.delete(frame.size() - 1);
            end
            1: repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
            default: ;
        endcase
    endtask

    // Mostly well-formed descriptors, some noise and some corrupted ones
    task send_random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            frame.delete();
            repeat ($urandom_range(1, 16)) frame.push_back(8'($urandom));
        end
        else
        begin
            build_config_frame();
            if (pick < 30)
                frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        end
        send_frame();
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single byte stream: header never arrives
        frame = '{8'hFF};
        send_frame();
        // length low byte only, above the cap
        frame = '{8'h00, 8'h00, 8'd200};
        send_frame();
        // length low byte only, under the cap
        frame = '{8'd9, TYPE_CONFIG, 8'h30};
        send_frame();
        // high length byte and top config value
        frame = '{8'd9, TYPE_CONFIG, 8'hFF, 8'hFF, 8'd1, 8'hFF};
        send_frame();
        // zero total length: walk never starts
        frame = '{8'd9, TYPE_CONFIG, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50, 8'd9};
        send_frame();
        wait_drained();

        while (bytes_sent < 180)
            send_random_frame();
        wait_drained();

        // result side holds off while short streams pile up behind it
        hold_requests++;
        repeat (120)
        begin
            frame.delete();
            repeat ($urandom_range(1, 2)) frame.push_back(8'($urandom));
            send_frame();
        end
        wait_drained();

        // stretch with no idling on either side
        calm = 1'b1;
        while (bytes_sent < 480)
            send_random_frame();
        calm = 1'b0;

        // stream long enough to saturate the byte position
        build_config_frame();
        repeat (520) frame.push_back(8'($urandom));
        send_frame();

        while (bytes_sent < ITEM_TARGET || frames_sent < MIN_RESULTS)
            send_random_frame();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_waiting == 0)
            $display("usb_hid_config_descriptor_parser verification clean");
        else
            $display("usb_hid_config_descriptor_parser verification failed");
        $finish;
    end

endmodule
